### rtl/edtc_pkg.sv
// Shared types and constants for the escaped delimiter token counter.
package edtc_pkg;

    localparam int BYTE_W   = 8;
    localparam int DELIM_W  = 64;
    localparam int DLEN_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int RESULT_W = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0]   ESC_BYTE      = 8'h5C;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 16'hFFFF;
    localparam logic [DELIM_W-1:0]  DELIM_RST     = 64'd44;
    localparam logic [DLEN_W-1:0]   DLEN_RST      = 4'd1;
    localparam logic [RESULT_W-1:0] RESULT_NO_DELIM = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_BYTES = 1'b0,
        REG_DELIM_LEN   = 1'b1
    } cfg_reg_t;

    // Per-cell compare status handed to the control logic
    typedef struct packed {
        logic match_ok;   // byte agrees with its delimiter byte, or cell is beyond the delimiter
        logic esc_hit;    // cell sits just before the delimiter and holds a backslash
    } cell_stat_t;

endpackage

### rtl/edtc_cell.sv
// One window cell: holds a recent byte, passes it on and compares against the delimiter.
module edtc_cell
    import edtc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 4
)
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic [BYTE_W-1:0]    byte_in,
    input  logic [DELIM_W-1:0]   delim_bytes,
    input  logic [LEN_W-1:0]     eff_len,
    output logic [BYTE_W-1:0]    byte_out,
    output cell_stat_t           stat
);

    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  pos;
    logic [2:0]        sel;
    logic [BYTE_W-1:0] want;
    logic              in_use;

    // Held byte moves to the neighbor on every shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Byte entering this cell is window position IDX after the shift;
    // it lines up with delimiter byte eff_len-1-IDX.
    assign in_use = (LEN_W'(IDX) < eff_len);
    assign pos    = eff_len - LEN_W'(1) - LEN_W'(IDX);
    assign sel    = 3'(pos);
    assign want   = delim_bytes[BYTE_W*sel +: BYTE_W];

    always_comb
    begin
        stat.match_ok = !in_use || (byte_in == want);
        stat.esc_hit  = (LEN_W'(IDX) == eff_len) && (byte_in == ESC_BYTE);
    end

endmodule

### rtl/escaped_delimiter_token_counter.sv
// Top level: delimiter window chain, match control and result register.
//
//  channel   | signals                          | direction | payload
//  ----------+----------------------------------+-----------+------------------------
//  byte      | byte_valid, byte_stall           | in        | ch[7:0]
//  count     | count_valid, count_stall         | out       | token_count[16:0] signed
//  cfg       | cfg_valid, cfg_ready             | in        | cfg_index, cfg_data[63:0]
//
// One byte is taken per clock while byte_stall is low; the window cells compare all delimiter
// positions in the same cycle, so match, escape check and count update are
// combinational. The count is registered and appears in the cycle after the zero byte.
// Async reset restores delim_bytes = ',' and delim_len = 1 and clears the string state.
// The byte channel stalls only while a finished count waits on a stalled output.
module escaped_delimiter_token_counter
    import edtc_pkg::*;
#(
    parameter int MAX_DELIM = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [BYTE_W-1:0]           ch,
    output logic                        count_valid,
    input  logic                        count_stall,
    output logic signed [RESULT_W-1:0]  token_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DELIM_W-1:0]          cfg_data
);

    localparam int LEN_W  = $clog2(MAX_DELIM + 1);
    localparam int SEEN_W = $clog2(MAX_DELIM + 2);
    localparam int SKIP_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_DELIM + 1);
    localparam logic [DLEN_W-1:0] DLEN_CAP = DLEN_W'(MAX_DELIM);

    // Configuration registers
    logic [DELIM_W-1:0] delim_bytes_reg;
    logic [DLEN_W-1:0]  delim_len_reg;

    // String state
    logic [SEEN_W-1:0]  seen_reg,  seen_next;
    logic [SKIP_W-1:0]  skip_reg,  skip_next;
    logic               seg_reg,   seg_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]        result_reg,    result_next;

    logic               accept;
    logic               is_end;
    logic               shift_en;
    logic [LEN_W-1:0]   eff_len;
    logic [DLEN_W-1:0]  len_cap;
    logic [SEEN_W-1:0]  seen_post;
    logic [SEEN_W-1:0]  len_ext;
    logic               all_match;
    logic               any_esc;
    logic               hit;
    logic               escaped;

    logic [BYTE_W-1:0]  chain [0:MAX_DELIM];
    cell_stat_t         stat  [0:MAX_DELIM];

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= DELIM_RST;
            delim_len_reg   <= DLEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DELIM_BYTES: delim_bytes_reg <= cfg_data;
                REG_DELIM_LEN:   delim_len_reg   <= cfg_data[DLEN_W-1:0];
            endcase
        end
    end

    // Effective delimiter length: capped, and cut at the first zero byte
    assign len_cap = (delim_len_reg > DLEN_CAP) ? DLEN_CAP : delim_len_reg;

    always_comb
    begin
        eff_len = LEN_W'(len_cap);
        for (int k = MAX_DELIM - 1; k >= 0; k--)
        begin
            if ((DLEN_W'(k) < len_cap) && (delim_bytes_reg[BYTE_W*k +: BYTE_W] == '0))
            begin
                eff_len = LEN_W'(k);
            end
        end
    end

    // Handshake
    assign byte_stall = out_valid_reg && count_stall;
    assign accept     = byte_valid && !byte_stall;
    assign is_end     = (ch == '0);
    assign shift_en   = accept && !is_end;

    // Window chain: cell k sees window position k after the shift
    assign chain[0] = ch;

    for (genvar k = 0; k <= MAX_DELIM; k++)
    begin : g_cell
        if (k < MAX_DELIM)
        begin : g_link
            edtc_cell #(
                .IDX   (k),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk         (clk),
                .shift_en    (shift_en),
                .byte_in     (chain[k]),
                .delim_bytes (delim_bytes_reg),
                .eff_len     (eff_len),
                .byte_out    (chain[k+1]),
                .stat        (stat[k])
            );
        end
        else
        begin : g_tail
            edtc_cell #(
                .IDX   (k),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk         (clk),
                .shift_en    (shift_en),
                .byte_in     (chain[k]),
                .delim_bytes (delim_bytes_reg),
                .eff_len     (eff_len),
                .byte_out    (),
                .stat        (stat[k])
            );
        end
    end

    // Reduce cell status
    always_comb
    begin
        all_match = 1'b1;
        any_esc   = 1'b0;
        for (int k = 0; k <= MAX_DELIM; k++)
        begin
            all_match = all_match && stat[k].match_ok;
            any_esc   = any_esc || stat[k].esc_hit;
        end
    end

    assign seen_post = (seen_reg < SEEN_MAX) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign len_ext   = SEEN_W'(eff_len);
    assign hit       = (eff_len != '0) && (skip_reg == '0) && (seen_post >= len_ext)
                       && all_match;
    assign escaped   = (seen_post > len_ext) && any_esc;

    // String state update
    always_comb
    begin
        seen_next  = seen_reg;
        skip_next  = skip_reg;
        seg_next   = seg_reg;
        count_next = count_reg;
        if (accept && is_end)
        begin
            seen_next  = '0;
            skip_next  = '0;
            seg_next   = 1'b1;
            count_next = '0;
        end
        else if (accept)
        begin
            seen_next = seen_post;
            seg_next  = 1'b0;
            if (eff_len != '0)
            begin
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
                else if (hit)
                begin
                    if (!escaped && count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    seg_next  = 1'b1;
                    skip_next = SKIP_W'(eff_len - LEN_W'(1));
                end
            end
        end
    end

    // Result for the zero byte
    always_comb
    begin
        if (seen_reg == '0)
        begin
            result_next = '0;
        end
        else if (eff_len == '0)
        begin
            result_next = RESULT_NO_DELIM;
        end
        else if (!seg_reg && count_reg != COUNT_MAX)
        begin
            result_next = RESULT_W'(count_reg) + RESULT_W'(1);
        end
        else
        begin
            result_next = RESULT_W'(count_reg);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && count_stall;
        if (accept && is_end)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            skip_reg      <= '0;
            seg_reg       <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            skip_reg      <= skip_next;
            seg_reg       <= seg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_end)
        begin
            result_reg <= result_next;
        end
    end

    assign count_valid = out_valid_reg;
    assign token_count = signed'(result_reg);

endmodule

### rtl/edtc_checker.sv
// Port-level checker for the escaped delimiter token counter, with its bind.
module edtc_checker
    import edtc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic                        byte_stall,
    input  logic [BYTE_W-1:0]           ch,
    input  logic                        count_valid,
    input  logic                        count_stall,
    input  logic signed [RESULT_W-1:0]  token_count,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DELIM_W-1:0]          cfg_data
);

    // A stalled count is held
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && count_stall |=> count_valid && $stable(token_count))
        else $error("count changed while stalled");

    // A zero byte transfer always yields a count next cycle
    a_end_gives_count: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && ch == '0 |=> count_valid)
        else $error("no count after end of string");

    // A non-zero byte never yields a count
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && ch != '0 && !count_stall |=> !count_valid)
        else $error("count without end of string");

    // The byte side stalls only behind a stalled count
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> count_valid && count_stall)
        else $error("byte stall without pending count");

    // Count is 0..65535 or -1
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> token_count[RESULT_W-1] == 1'b0 || token_count == -17'sd1)
        else $error("count out of range");

endmodule

bind escaped_delimiter_token_counter edtc_checker u_edtc_checker (.*);
